// ===== sv/dosw_pkg.sv =====
// ----------------------------------------------------------------------------
// dosw_pkg
// Shared types and codes of the display order screen writer.
// ----------------------------------------------------------------------------
package dosw_pkg;

    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int IDX_W = 12;

    localparam logic [3:0] OP_CLEAR  = 4'd0;
    localparam logic [3:0] OP_BEGIN  = 4'd1;
    localparam logic [3:0] OP_SETADR = 4'd2;
    localparam logic [3:0] OP_DATA   = 4'd3;
    localparam logic [3:0] OP_CURSOR = 4'd4;
    localparam logic [3:0] OP_REPEAT = 4'd5;
    localparam logic [3:0] OP_FIELD  = 4'd6;
    localparam logic [3:0] OP_END    = 4'd7;
    localparam logic [3:0] OP_READ   = 4'd8;
    localparam logic [3:0] OP_HEADER = 4'd9;

    localparam logic [7:0] CHAR_BLANK = 8'h40;

    typedef struct packed {
        logic [3:0]       op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [IDX_W-1:0] idx;
        logic [7:0]       ch;
        logic             has;
        logic [7:0]       attr;
        logic [15:0]      len;
    } t_cmd;

endpackage

// ===== sv/dosw_front.sv =====
// ----------------------------------------------------------------------------
// dosw_front
// Decodes an incoming request: clamps the 1-based address and forms the
// linear cell index.
// ----------------------------------------------------------------------------
module dosw_front import dosw_pkg::*; #(
    parameter int ROWS = 24,
    parameter int COLS = 80
) (
    input  logic [3:0]  i_type,
    input  logic [55:0] i_data,
    output t_cmd        o_cmd
);

    logic [7:0]       w_ra;
    logic [7:0]       w_ca;
    logic [ROW_W-1:0] w_row;
    logic [COL_W-1:0] w_col;

    assign w_ra = i_data[7:0];
    assign w_ca = i_data[15:8];

    always_comb begin
        if (w_ra == 8'd0) begin
            w_row = '0;
        end else if (w_ra > 8'(ROWS)) begin
            w_row = ROW_W'(ROWS - 1);
        end else begin
            w_row = ROW_W'(w_ra - 8'd1);
        end
        if (w_ca == 8'd0) begin
            w_col = '0;
        end else if (w_ca > 8'(COLS)) begin
            w_col = COL_W'(COLS - 1);
        end else begin
            w_col = COL_W'(w_ca - 8'd1);
        end
    end

    always_comb begin
        o_cmd.op   = i_type;
        o_cmd.row  = w_row;
        o_cmd.col  = w_col;
        o_cmd.idx  = IDX_W'(w_row) * IDX_W'(COLS) + IDX_W'(w_col);
        o_cmd.ch   = i_data[23:16];
        o_cmd.has  = i_data[24];
        o_cmd.attr = i_data[32:25];
        o_cmd.len  = i_data[48:33];
    end

endmodule

// ===== sv/dosw_queue.sv =====
// ----------------------------------------------------------------------------
// dosw_queue
// Two-entry request queue between the decoder and the executor.
// ----------------------------------------------------------------------------
module dosw_queue import dosw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== sv/dosw_back.sv =====
// ----------------------------------------------------------------------------
// dosw_back
// Executes display orders on the character and attribute memories and
// registers one result per request.
// ----------------------------------------------------------------------------
module dosw_back import dosw_pkg::*; #(
    parameter int ROWS = 24,
    parameter int COLS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [47:0] o_data
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
    localparam logic [IDX_W-1:0] BOT_IDX  = IDX_W'((ROWS - 1) * COLS);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_REP   = 3'd2;
    localparam logic [2:0] S_FLD   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [7:0] mem_char [CELLS];
    logic [8:0] mem_attr [CELLS];

    logic [2:0]       r_state, n_state;
    logic [7:0]       r_clear_char;
    logic [7:0]       r_fill, n_fill;
    logic             r_init, n_init;
    logic [ROW_W-1:0] r_pos_row, n_pos_row;
    logic [COL_W-1:0] r_pos_col, n_pos_col;
    logic [IDX_W-1:0] r_pos_idx, n_pos_idx;
    logic [ROW_W-1:0] r_cur_row, n_cur_row;
    logic [COL_W-1:0] r_cur_col, n_cur_col;
    logic             r_halted, n_halted;
    logic             r_placed, n_placed;
    logic [5:0]       r_wr, n_wr;
    logic [7:0]       r_wc, n_wc;
    logic [IDX_W-1:0] r_widx, n_widx;
    logic [15:0]      r_cnt, n_cnt;
    t_cmd             r_cmd, n_cmd;
    logic             r_is_read, n_is_read;
    logic [7:0]       r_rd_char;
    logic [8:0]       r_rd_attr;
    logic             r_out_valid, n_out_valid;
    logic [47:0]      r_out_data, n_out_data;

    logic             w_we_c, w_we_a, w_rd;
    logic [IDX_W-1:0] w_addr;
    logic [7:0]       w_char;
    logic [8:0]       w_attr;
    logic             w_rep_go;
    logic [7:0]       w_cell_char;
    logic [8:0]       w_cell_attr;

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (w_we_c) begin
            mem_char[w_addr[AW-1:0]] <= w_char;
        end
        if (w_we_a) begin
            mem_attr[w_addr[AW-1:0]] <= w_attr;
        end
        if (w_rd) begin
            r_rd_char <= mem_char[w_addr[AW-1:0]];
            r_rd_attr <= mem_attr[w_addr[AW-1:0]];
        end
    end

    assign w_rep_go = (r_wr < 6'(ROWS)) &&
                      ((r_wr < 6'(r_cmd.row)) ||
                       ((r_wr == 6'(r_cmd.row)) && (r_wc <= 8'(r_cmd.col))));

    assign w_cell_char = r_is_read ? r_rd_char : 8'd0;
    assign w_cell_attr = r_is_read ? r_rd_attr : 9'd0;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_init      = r_init;
        n_pos_row   = r_pos_row;
        n_pos_col   = r_pos_col;
        n_pos_idx   = r_pos_idx;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_halted    = r_halted;
        n_placed    = r_placed;
        n_wr        = r_wr;
        n_wc        = r_wc;
        n_widx      = r_widx;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_is_read   = r_is_read;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        w_we_c      = 1'b0;
        w_we_a      = 1'b0;
        w_rd        = 1'b0;
        w_addr      = r_widx;
        w_char      = r_fill;
        w_attr      = '0;

        unique case (r_state)
            S_SWEEP: begin
                w_we_c = 1'b1;
                w_we_a = 1'b1;
                n_widx = r_widx + 1'b1;
                if (r_widx == LAST_IDX) begin
                    n_state = r_init ? S_IDLE : S_EMIT;
                    n_init  = 1'b0;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd;
                    n_is_read = 1'b0;
                    n_state   = S_EMIT;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_fill    = r_clear_char;
                            n_widx    = '0;
                            n_cur_row = '0;
                            n_cur_col = COL_W'(COLS - 1);
                            n_state   = S_SWEEP;
                        end
                        OP_BEGIN: begin
                            n_pos_row = '0;
                            n_pos_col = '0;
                            n_pos_idx = '0;
                            n_halted  = 1'b0;
                            n_placed  = 1'b0;
                        end
                        OP_SETADR: begin
                            n_pos_row = i_cmd.row;
                            n_pos_col = i_cmd.col;
                            n_pos_idx = i_cmd.idx;
                            n_halted  = 1'b0;
                        end
                        OP_DATA: begin
                            if (!r_halted) begin
                                w_we_c = 1'b1;
                                w_addr = r_pos_idx;
                                w_char = i_cmd.ch;
                                if (8'(r_pos_col) + 8'd1 >= 8'(COLS)) begin
                                    n_pos_col = '0;
                                    if (6'(r_pos_row) + 6'd1 >= 6'(ROWS)) begin
                                        n_pos_row = ROW_W'(ROWS - 1);
                                        n_pos_idx = BOT_IDX;
                                        n_halted  = 1'b1;
                                    end else begin
                                        n_pos_row = r_pos_row + 1'b1;
                                        n_pos_idx = r_pos_idx + 1'b1;
                                    end
                                end else begin
                                    n_pos_col = r_pos_col + 1'b1;
                                    n_pos_idx = r_pos_idx + 1'b1;
                                end
                            end
                        end
                        OP_CURSOR: begin
                            n_cur_row = i_cmd.row;
                            n_cur_col = i_cmd.col;
                            n_placed  = 1'b1;
                        end
                        OP_REPEAT: begin
                            n_wr    = 6'(r_pos_row);
                            n_wc    = 8'(r_pos_col);
                            n_widx  = r_pos_idx;
                            n_state = S_REP;
                        end
                        OP_FIELD: begin
                            if (i_cmd.len != 16'd0) begin
                                n_wc    = 8'(r_pos_col);
                                n_widx  = r_pos_idx;
                                n_cnt   = '0;
                                n_state = S_FLD;
                            end
                        end
                        OP_END: begin
                            if (!r_placed) begin
                                n_cur_row = r_pos_row;
                                n_cur_col = r_pos_col;
                            end
                        end
                        OP_READ: begin
                            w_rd      = 1'b1;
                            w_addr    = i_cmd.idx;
                            n_is_read = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REP: begin
                if (w_rep_go) begin
                    w_we_c = 1'b1;
                    w_char = r_cmd.has ? r_cmd.ch : CHAR_BLANK;
                    n_widx = r_widx + 1'b1;
                    if (r_wc + 8'd1 >= 8'(COLS)) begin
                        n_wc = '0;
                        n_wr = r_wr + 6'd1;
                    end else begin
                        n_wc = r_wc + 8'd1;
                    end
                end else begin
                    n_pos_col = COL_W'(r_wc);
                    if (r_wr >= 6'(ROWS)) begin
                        n_pos_row = ROW_W'(ROWS - 1);
                        n_pos_idx = BOT_IDX;
                    end else begin
                        n_pos_row = ROW_W'(r_wr);
                        n_pos_idx = r_widx;
                    end
                    n_state = S_EMIT;
                end
            end
            S_FLD: begin
                if ((r_cnt < r_cmd.len) && (r_wc < 8'(COLS))) begin
                    w_we_a = 1'b1;
                    w_attr = {(r_cnt == 16'd0), r_cmd.attr};
                    w_we_c = r_cmd.has;
                    w_char = r_cmd.ch;
                    n_widx = r_widx + 1'b1;
                    n_wc   = r_wc + 8'd1;
                    n_cnt  = r_cnt + 16'd1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_pos_col, r_pos_row, r_cur_col, r_cur_row,
                                   w_cell_attr, w_cell_char};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_init       <= 1'b1;
            r_fill       <= CHAR_BLANK;
            r_widx       <= '0;
            r_clear_char <= CHAR_BLANK;
            r_pos_row    <= '0;
            r_pos_col    <= '0;
            r_pos_idx    <= '0;
            r_cur_row    <= '0;
            r_cur_col    <= COL_W'(COLS - 1);
            r_halted     <= 1'b0;
            r_placed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_fill      <= n_fill;
            r_widx      <= n_widx;
            if (i_cfg_we) begin
                r_clear_char <= i_cfg_data;
            end
            r_pos_row   <= n_pos_row;
            r_pos_col   <= n_pos_col;
            r_pos_idx   <= n_pos_idx;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_halted    <= n_halted;
            r_placed    <= n_placed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr       <= n_wr;
        r_wc       <= n_wc;
        r_cnt      <= n_cnt;
        r_cmd      <= n_cmd;
        r_is_read  <= n_is_read;
        r_out_data <= n_out_data;
    end

endmodule

// ===== sv/display_order_screen_writer_core.sv =====
// ----------------------------------------------------------------------------
// display_order_screen_writer_core
// Screen engine executing decoded display orders on a character and
// attribute store.
// ----------------------------------------------------------------------------
// Usage: one request enters on the s_axis side (order kind in tuser), one
// result leaves on the m_axis side per request, in order. The clear
// character is written through i_cfg_we / i_cfg_data while idle.
// Requests are decoded and placed in a two-entry queue; the executor takes
// them one at a time from there.
// In the executor, clear sweeps all ROWS*COLS cells, and repeat and a
// non-empty start field walk cells from the write address, one cell per
// cycle; the other orders touch at most one cell before their result.
// After reset the executor sweeps all ROWS*COLS cells before taking the
// first request; the queue still accepts up to two requests meanwhile.
// A stalled receiver holds the result register; the executor then waits
// with the next result and the queue fills, dropping s_axis_tready.
// ----------------------------------------------------------------------------
module display_order_screen_writer_core import dosw_pkg::*; #(
    parameter int ROWS = 24,
    parameter int COLS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row_addr[7:0], col_addr[15:8], char_byte[23:16], has_char[24],
    // field_attr[32:25], field_len[48:33], zero above
    input  logic [55:0] s_axis_tdata,
    // req_type[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_char[7:0], cell_color[11:8], cell_reverse[12], cell_blink[13],
    // cell_underline[14], cell_protected[15], cell_field_start[16],
    // cursor_row[21:17], cursor_col[28:22], write_row[33:29],
    // write_col[40:34], zero above
    output logic [47:0] m_axis_tdata
);

    t_cmd w_dec_cmd;
    t_cmd w_q_cmd;
    logic w_full;
    logic w_empty;
    logic w_pop;
    logic w_push;

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    dosw_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
        .i_type (s_axis_tuser),
        .i_data (s_axis_tdata),
        .o_cmd  (w_dec_cmd)
    );

    dosw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_dec_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_q_cmd)
    );

    dosw_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_empty    (w_empty),
        .i_cmd      (w_q_cmd),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule
